// ----- hw/rtl/hsvrgb_pkg.sv -----
// Shared types and constants for the HSV percent to RGB888 converter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package hsvrgb_pkg;

   // Color arithmetic constants
   localparam int unsigned FULL_CIRCLE = 360;
   localparam int unsigned SECTOR      = 60;
   localparam int unsigned PERCENT     = 100;
   localparam int unsigned FULL_SCALE  = 255;

   // Reciprocal multipliers: floor(x / d) = (x * M) >> S over the value range in use
   localparam int unsigned CIRCLE_RECIP = 23301;   // floor(2^23 / 360), may be one low
   localparam int unsigned CIRCLE_SHIFT = 23;
   localparam int unsigned PCT_RECIP    = 10486;   // ceil(2^20 / 100), x <= 10000
   localparam int unsigned PCT_SHIFT    = 20;
   localparam int unsigned SCALE_RECIP  = 32897;   // ceil(2^23 / 255), x <= 25500
   localparam int unsigned SCALE_SHIFT  = 23;
   localparam int unsigned BYTE_RECIP   = 41944;   // ceil(2^22 / 100), x <= 25500
   localparam int unsigned BYTE_SHIFT   = 22;

   // 60-degree hue region
   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW,
      SECTOR_YELLOW_GREEN,
      SECTOR_GREEN_CYAN,
      SECTOR_CYAN_BLUE,
      SECTOR_BLUE_MAGENTA,
      SECTOR_MAGENTA_RED
   } region_type;

   // Hue reduction result
   typedef struct packed {
      region_type  region;
      logic [7:0]  rem;
      logic [6:0]  sat;
      logic [6:0]  val;
   } hue_data_type;

   // Levels in percent
   typedef struct packed {
      region_type  region;
      logic [6:0]  val;
      logic [6:0]  p;
      logic [6:0]  q;
      logic [6:0]  t;
   } level_data_type;

endpackage

`default_nettype wire

// ----- hw/rtl/hsvrgb_hue_reduce.sv -----
// Hue reduction pipeline: hue mod 360, region and scaled remainder, percent clamps.
// Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_hue_reduce (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic [15:0]                in_hue,
   input  wire logic [7:0]                 in_sat,
   input  wire logic [7:0]                 in_val,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output hsvrgb_pkg::hue_data_type        out_data
);

   localparam int unsigned STAGES = 3;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] adv;

   logic [15:0] hue1_ff;
   logic [30:0] prod1_ff, prod1_in;
   logic [6:0]  sat1_ff, sat1_in, val1_ff, val1_in;

   logic [8:0]  h2_ff, h2_in;
   logic [6:0]  sat2_ff, val2_ff;

   hsvrgb_pkg::hue_data_type data3_ff, data3_in;

   logic [7:0]  quot;
   logic [15:0] quot_x;
   logic [15:0] rem_wide;
   logic [8:0]  base;
   logic [5:0]  r60;
   logic [9:0]  r60_x17;

   // Advance a stage when it is empty or its successor advances
   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_data  = data3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= in_valid;
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // Stage 1: reciprocal product for hue / 360, clamp percents
   always_comb begin
      prod1_in = 31'(32'(in_hue) * 32'(hsvrgb_pkg::CIRCLE_RECIP));
      sat1_in  = (in_sat > 8'(hsvrgb_pkg::PERCENT)) ? 7'(hsvrgb_pkg::PERCENT) : in_sat[6:0];
      val1_in  = (in_val > 8'(hsvrgb_pkg::PERCENT)) ? 7'(hsvrgb_pkg::PERCENT) : in_val[6:0];
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         hue1_ff  <= in_hue;
         prod1_ff <= prod1_in;
         sat1_ff  <= sat1_in;
         val1_ff  <= val1_in;
      end
   end

   // Stage 2: remainder of hue / 360, one correction step
   always_comb begin
      quot     = prod1_ff[hsvrgb_pkg::CIRCLE_SHIFT +: 8];
      quot_x   = 16'(quot) * 16'(hsvrgb_pkg::FULL_CIRCLE);
      rem_wide = hue1_ff - quot_x;
      if (rem_wide >= 16'(hsvrgb_pkg::FULL_CIRCLE)) begin
         h2_in = 9'(rem_wide - 16'(hsvrgb_pkg::FULL_CIRCLE));
      end else begin
         h2_in = rem_wide[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         h2_ff   <= h2_in;
         sat2_ff <= sat1_ff;
         val2_ff <= val1_ff;
      end
   end

   // Stage 3: region by compare, remainder scaled by 255/60 = 17/4
   always_comb begin
      data3_in = '0;
      if (h2_ff < 9'(hsvrgb_pkg::SECTOR)) begin
         data3_in.region = hsvrgb_pkg::SECTOR_RED_YELLOW;
         base = 9'd0;
      end else if (h2_ff < 9'(2 * hsvrgb_pkg::SECTOR)) begin
         data3_in.region = hsvrgb_pkg::SECTOR_YELLOW_GREEN;
         base = 9'(hsvrgb_pkg::SECTOR);
      end else if (h2_ff < 9'(3 * hsvrgb_pkg::SECTOR)) begin
         data3_in.region = hsvrgb_pkg::SECTOR_GREEN_CYAN;
         base = 9'(2 * hsvrgb_pkg::SECTOR);
      end else if (h2_ff < 9'(4 * hsvrgb_pkg::SECTOR)) begin
         data3_in.region = hsvrgb_pkg::SECTOR_CYAN_BLUE;
         base = 9'(3 * hsvrgb_pkg::SECTOR);
      end else if (h2_ff < 9'(5 * hsvrgb_pkg::SECTOR)) begin
         data3_in.region = hsvrgb_pkg::SECTOR_BLUE_MAGENTA;
         base = 9'(4 * hsvrgb_pkg::SECTOR);
      end else begin
         data3_in.region = hsvrgb_pkg::SECTOR_MAGENTA_RED;
         base = 9'(5 * hsvrgb_pkg::SECTOR);
      end
      r60          = 6'(h2_ff - base);
      r60_x17      = 10'(r60) * 10'd17;
      data3_in.rem = r60_x17[9:2];
      data3_in.sat = sat2_ff;
      data3_in.val = val2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         data3_ff <= data3_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/hsvrgb_levels.sv -----
// Level pipeline: forms p, q and t in percent with truncating divisions.
// Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_levels (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire hsvrgb_pkg::hue_data_type   in_data,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output hsvrgb_pkg::level_data_type      out_data
);

   localparam int unsigned STAGES = 5;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] adv;

   // Stage 1
   hsvrgb_pkg::region_type region1_ff, region2_ff, region3_ff, region4_ff;
   logic [6:0]  val1_ff, val2_ff, val3_ff, val4_ff;
   logic [13:0] pnum1_ff, pnum1_in;
   logic [14:0] sr1_ff, sr1_in, st1_ff, st1_in;
   // Stage 2
   logic [26:0] pm2_ff, pm2_in;
   logic [29:0] am2_ff, am2_in, bm2_ff, bm2_in;
   // Stage 3
   logic [6:0]  p3_ff, p4_ff;
   logic [13:0] qnum3_ff, qnum3_in, tnum3_ff, tnum3_in;
   // Stage 4
   logic [26:0] qm4_ff, qm4_in, tm4_ff, tm4_in;
   // Stage 5
   hsvrgb_pkg::level_data_type data5_ff, data5_in;

   logic [6:0] adiv, bdiv;

   // Advance a stage when it is empty or its successor advances
   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_data  = data5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= in_valid;
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // Stage 1: v*(100-s), s*rem, s*(255-rem)
   always_comb begin
      pnum1_in = 14'(in_data.val) * (14'(hsvrgb_pkg::PERCENT) - 14'(in_data.sat));
      sr1_in   = 15'(in_data.sat) * 15'(in_data.rem);
      st1_in   = 15'(in_data.sat) * (15'(hsvrgb_pkg::FULL_SCALE) - 15'(in_data.rem));
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         region1_ff <= in_data.region;
         val1_ff    <= in_data.val;
         pnum1_ff   <= pnum1_in;
         sr1_ff     <= sr1_in;
         st1_ff     <= st1_in;
      end
   end

   // Stage 2: reciprocal products for /100 and /255
   always_comb begin
      pm2_in = 27'(32'(pnum1_ff) * 32'(hsvrgb_pkg::PCT_RECIP));
      am2_in = 30'(32'(sr1_ff) * 32'(hsvrgb_pkg::SCALE_RECIP));
      bm2_in = 30'(32'(st1_ff) * 32'(hsvrgb_pkg::SCALE_RECIP));
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         region2_ff <= region1_ff;
         val2_ff    <= val1_ff;
         pm2_ff     <= pm2_in;
         am2_ff     <= am2_in;
         bm2_ff     <= bm2_in;
      end
   end

   // Stage 3: take quotients, form q and t numerators
   always_comb begin
      adiv     = am2_ff[hsvrgb_pkg::SCALE_SHIFT +: 7];
      bdiv     = bm2_ff[hsvrgb_pkg::SCALE_SHIFT +: 7];
      qnum3_in = 14'(val2_ff) * (14'(hsvrgb_pkg::PERCENT) - 14'(adiv));
      tnum3_in = 14'(val2_ff) * (14'(hsvrgb_pkg::PERCENT) - 14'(bdiv));
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         region3_ff <= region2_ff;
         val3_ff    <= val2_ff;
         p3_ff      <= pm2_ff[hsvrgb_pkg::PCT_SHIFT +: 7];
         qnum3_ff   <= qnum3_in;
         tnum3_ff   <= tnum3_in;
      end
   end

   // Stage 4: reciprocal products for q and t
   always_comb begin
      qm4_in = 27'(32'(qnum3_ff) * 32'(hsvrgb_pkg::PCT_RECIP));
      tm4_in = 27'(32'(tnum3_ff) * 32'(hsvrgb_pkg::PCT_RECIP));
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         region4_ff <= region3_ff;
         val4_ff    <= val3_ff;
         p4_ff      <= p3_ff;
         qm4_ff     <= qm4_in;
         tm4_ff     <= tm4_in;
      end
   end

   // Stage 5: take quotients, pack levels
   always_comb begin
      data5_in.region = region4_ff;
      data5_in.val    = val4_ff;
      data5_in.p      = p4_ff;
      data5_in.q      = qm4_ff[hsvrgb_pkg::PCT_SHIFT +: 7];
      data5_in.t      = tm4_ff[hsvrgb_pkg::PCT_SHIFT +: 7];
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         data5_ff <= data5_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/hsvrgb_scale_select.sv -----
// Output pipeline: scales percent levels to 0..255 and routes them by region.
// Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_scale_select (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire hsvrgb_pkg::level_data_type  in_data,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output logic [7:0]                       out_red,
   output logic [7:0]                       out_green,
   output logic [7:0]                       out_blue
);

   localparam int unsigned STAGES = 3;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] adv;

   hsvrgb_pkg::region_type region1_ff, region2_ff;
   logic [14:0] vx1_ff, vx1_in, px1_ff, px1_in, qx1_ff, qx1_in, tx1_ff, tx1_in;
   logic [30:0] vm2_ff, vm2_in, pm2_ff, pm2_in, qm2_ff, qm2_in, tm2_ff, tm2_in;
   logic [7:0]  red3_ff, red3_in, green3_ff, green3_in, blue3_ff, blue3_in;

   logic [7:0] vs, ps, qs, ts;

   // Advance a stage when it is empty or its successor advances
   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_red   = red3_ff;
   assign out_green = green3_ff;
   assign out_blue  = blue3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= in_valid;
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // Stage 1: multiply each level by 255
   always_comb begin
      vx1_in = 15'(in_data.val) * 15'(hsvrgb_pkg::FULL_SCALE);
      px1_in = 15'(in_data.p) * 15'(hsvrgb_pkg::FULL_SCALE);
      qx1_in = 15'(in_data.q) * 15'(hsvrgb_pkg::FULL_SCALE);
      tx1_in = 15'(in_data.t) * 15'(hsvrgb_pkg::FULL_SCALE);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         region1_ff <= in_data.region;
         vx1_ff     <= vx1_in;
         px1_ff     <= px1_in;
         qx1_ff     <= qx1_in;
         tx1_ff     <= tx1_in;
      end
   end

   // Stage 2: reciprocal products for /100
   always_comb begin
      vm2_in = 31'(32'(vx1_ff) * 32'(hsvrgb_pkg::BYTE_RECIP));
      pm2_in = 31'(32'(px1_ff) * 32'(hsvrgb_pkg::BYTE_RECIP));
      qm2_in = 31'(32'(qx1_ff) * 32'(hsvrgb_pkg::BYTE_RECIP));
      tm2_in = 31'(32'(tx1_ff) * 32'(hsvrgb_pkg::BYTE_RECIP));
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         region2_ff <= region1_ff;
         vm2_ff     <= vm2_in;
         pm2_ff     <= pm2_in;
         qm2_ff     <= qm2_in;
         tm2_ff     <= tm2_in;
      end
   end

   // Stage 3: take bytes and route channels by region
   always_comb begin
      vs = vm2_ff[hsvrgb_pkg::BYTE_SHIFT +: 8];
      ps = pm2_ff[hsvrgb_pkg::BYTE_SHIFT +: 8];
      qs = qm2_ff[hsvrgb_pkg::BYTE_SHIFT +: 8];
      ts = tm2_ff[hsvrgb_pkg::BYTE_SHIFT +: 8];
      case (region2_ff)
         hsvrgb_pkg::SECTOR_RED_YELLOW: begin
            red3_in = vs; green3_in = ts; blue3_in = ps;
         end
         hsvrgb_pkg::SECTOR_YELLOW_GREEN: begin
            red3_in = qs; green3_in = vs; blue3_in = ps;
         end
         hsvrgb_pkg::SECTOR_GREEN_CYAN: begin
            red3_in = ps; green3_in = vs; blue3_in = ts;
         end
         hsvrgb_pkg::SECTOR_CYAN_BLUE: begin
            red3_in = ps; green3_in = qs; blue3_in = vs;
         end
         hsvrgb_pkg::SECTOR_BLUE_MAGENTA: begin
            red3_in = ts; green3_in = ps; blue3_in = vs;
         end
         default: begin
            red3_in = vs; green3_in = ps; blue3_in = qs;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         red3_ff   <= red3_in;
         green3_ff <= green3_in;
         blue3_ff  <= blue3_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/hsv_percent_to_rgb888_unit.sv -----
// HSV (percent) to RGB888 converter, top level.
// Chains hsvrgb_hue_reduce, hsvrgb_levels and hsvrgb_scale_select; uses hsvrgb_pkg.
//
// Takes one transaction per clock cycle while the result side is not stalled and returns
// its color through a chain of registered stages: 3 stages reduce the hue, 5 form p, q
// and t, and 3 scale and route the channels. The depth is set by the chain of
// constant-reciprocal multiplies, each followed by a register. Every stage holds its
// own valid bit; a stage moves on when it is empty or the one after it moves, so
// req_ready drops only when all stages are full and rsp_ready is low. Keeps no state
// between transactions; no configuration.
`default_nettype none

module hsv_percent_to_rgb888_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_hue,
   input  wire logic [7:0]  req_saturation,
   input  wire logic [7:0]  req_brightness_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue
);

   logic                         hue_valid, hue_ready;
   hsvrgb_pkg::hue_data_type     hue_data;
   logic                         lvl_valid, lvl_ready;
   hsvrgb_pkg::level_data_type   lvl_data;

   // Reduce hue to region and remainder, clamp percents
   hsvrgb_hue_reduce u_hue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_hue    (req_hue),
      .in_sat    (req_saturation),
      .in_val    (req_brightness_value),
      .out_valid (hue_valid),
      .out_ready (hue_ready),
      .out_data  (hue_data)
   );

   // Form p, q, t in percent
   hsvrgb_levels u_levels (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hue_valid),
      .in_ready  (hue_ready),
      .in_data   (hue_data),
      .out_valid (lvl_valid),
      .out_ready (lvl_ready),
      .out_data  (lvl_data)
   );

   // Scale to bytes and route channels
   hsvrgb_scale_select u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lvl_valid),
      .in_ready  (lvl_ready),
      .in_data   (lvl_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

endmodule

`default_nettype wire
